[rtl/core/speq_pkg.sv]
`timescale 1ns / 1ps

package speq_pkg;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_POP    = 1'b1;

  localparam logic [1:0] STATUS_DONE       = 2'd0;
  localparam logic [1:0] STATUS_POP_EMPTY  = 2'd1;
  localparam logic [1:0] STATUS_INSERT_FULL = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [31:0] event_time;
    logic [15:0] job_number;
    logic [2:0]  event_kind;
  } req_item_t;

  typedef struct packed {
    logic [31:0] out_time;
    logic [15:0] out_job;
    logic [2:0]  out_kind;
    logic [1:0]  status;
    logic [4:0]  entries_held;
  } rsp_item_t;

  typedef struct packed {
    logic [31:0] ev_time;
    logic [15:0] job;
    logic [2:0]  kind;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

[rtl/core/sorted_event_priority_queue_top.sv]
`timescale 1ns / 1ps

// An accepted request enters the execute state, which registers the result beat.
// New requests are taken only in idle; all cells shift together in the execute step.
// A result that is not taken holds back the next item's execute cycle only.
// Reset clears the entry count, the control state and the result valid flag.
// Cell contents are not reset; the count alone marks which cells hold entries.
module sorted_event_priority_queue_top import speq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  state_t            state;
  state_t            state_next;
  req_item_t         cur;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W+4:0]  count_ext;
  rsp_item_t         rsp_next;
  cell_cmd_t         cmd;
  entry_t            new_entry;
  entry_t            cell_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] after;
  logic [QUEUE_DEPTH-1:0] occ;
  logic              exec_go;
  logic              is_insert;
  logic              full;
  logic              empty;

  assign new_entry = '{ev_time: cur.event_time, job: cur.job_number, kind: cur.event_kind};

  genvar g;
  for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_a;

    assign occ[g] = CNT_W'(g) < count;

    if (g == 0) begin : g_first
      assign left_e = new_entry;
      assign left_a = 1'b0;
    end else begin : g_mid
      assign left_e = cell_q[g-1];
      assign left_a = after[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign right_e = cell_q[g];
    end else begin : g_inner
      assign right_e = cell_q[g+1];
    end

    speq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .new_entry  (new_entry),
      .left_entry (left_e),
      .right_entry(right_e),
      .left_after (left_a),
      .occupied   (occ[g]),
      .after      (after[g]),
      .entry      (cell_q[g])
    );
  end

  assign is_insert = cur.mode == MODE_INSERT;
  assign full      = count == CNT_W'(QUEUE_DEPTH);
  assign empty     = count == '0;
  assign cmd.insert = exec_go && is_insert && !full;
  assign cmd.pop    = exec_go && !is_insert && !empty;

  always_comb begin
    count_next = count;
    if (cmd.insert) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  assign count_ext = {5'b0, count_next};

  always_comb begin
    rsp_next = '0;
    rsp_next.entries_held = count_ext[4:0];
    if (is_insert) begin
      rsp_next.status = full ? STATUS_INSERT_FULL : STATUS_DONE;
    end else if (empty) begin
      rsp_next.status = STATUS_POP_EMPTY;
    end else begin
      rsp_next.status   = STATUS_DONE;
      rsp_next.out_time = cell_q[0].ev_time;
      rsp_next.out_job  = cell_q[0].job;
      rsp_next.out_kind = cell_q[0].kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    exec_go    = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!rsp_valid || rsp_ready) begin
          exec_go    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cur <= req;
    end
    if (exec_go) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (exec_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STATUS_POP_EMPTY |-> rsp.entries_held == 5'd0)
    else $error("empty pop reported entries held");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == ST_EXEC)
    else $error("accepted beat did not enter execute");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> count == $past(count) - CNT_W'(1))
    else $error("pop did not decrement the count");

endmodule

[rtl/core/speq_cell.sv]
`timescale 1ns / 1ps

// One slot of the sorted list. The new entry lands in the first slot that is
// empty or holds a later time; every slot behind it takes its left neighbor.
module speq_cell import speq_pkg::*; (
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  entry_t    new_entry,
  input  entry_t    left_entry,
  input  entry_t    right_entry,
  input  logic      left_after,
  input  logic      occupied,
  output logic      after,
  output entry_t    entry
);

  logic take_new;

  assign after    = !occupied || (entry.ev_time > new_entry.ev_time);
  assign take_new = after && !left_after;

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (take_new) begin
        entry <= new_entry;
      end else if (left_after) begin
        entry <= left_entry;
      end
    end else if (cmd.pop) begin
      entry <= right_entry;
    end
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

class event_queue_scoreboard;
  int depth;
  int errors;
  speq_pkg::entry_t held_events[$];
  speq_pkg::rsp_item_t awaited_responses[$];

  function new(int depth_in);
    depth = depth_in;
    errors = 0;
  endfunction

  function int pending();
    return awaited_responses.size();
  endfunction

  // Applies one accepted request to the sorted event list and queues the response it yields.
  function void note_request(speq_pkg::req_item_t item);
    speq_pkg::rsp_item_t resp;
    speq_pkg::entry_t ev;
    int pos;
    resp = '0;
    resp.status = speq_pkg::STATUS_DONE;
    if (item.mode == speq_pkg::MODE_INSERT) begin
      if (held_events.size() >= depth) begin
        resp.status = speq_pkg::STATUS_INSERT_FULL;
      end else begin
        pos = 0;
        while (pos < held_events.size() && held_events[pos].ev_time <= item.event_time) pos++;
        ev.ev_time = item.event_time;
        ev.job = item.job_number;
        ev.kind = item.event_kind;
        held_events.insert(pos, ev);
      end
    end else begin
      if (held_events.size() == 0) begin
        resp.status = speq_pkg::STATUS_POP_EMPTY;
      end else begin
        ev = held_events.pop_front();
        resp.out_time = ev.ev_time;
        resp.out_job = ev.job;
        resp.out_kind = ev.kind;
      end
    end
    resp.entries_held = 5'(held_events.size());
    awaited_responses.push_back(resp);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function void check_response(speq_pkg::rsp_item_t got);
    speq_pkg::rsp_item_t want;
    if (awaited_responses.size() == 0) begin
      errors++;
      $display("%0t: response beat with none expected, expected nothing, actual %p", $time, got);
      return;
    end
    want = awaited_responses.pop_front();
    compare_field("out_time", want.out_time, got.out_time);
    compare_field("out_job", 32'(want.out_job), 32'(got.out_job));
    compare_field("out_kind", 32'(want.out_kind), 32'(got.out_kind));
    compare_field("status", 32'(want.status), 32'(got.status));
    compare_field("entries_held", 32'(want.entries_held), 32'(got.entries_held));
  endfunction
endclass

module tb_top;
  import speq_pkg::*;

  localparam int DEPTH = 16;
  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT = 300000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_item_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_item_t rsp;
  bit calm;

  event_queue_scoreboard sb = new(DEPTH);

  sorted_event_priority_queue_top #(
    .QUEUE_DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic req_item_t make_req(logic mode, logic [31:0] t, logic [15:0] job,
                                         logic [2:0] kind);
    req_item_t item;
    item.mode = mode;
    item.event_time = t;
    item.job_number = job;
    item.event_kind = kind;
    return item;
  endfunction

  function automatic req_item_t random_req(int insert_pct);
    req_item_t item;
    item.mode = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_POP;
    case ($urandom_range(0, 3))
      0: item.event_time = $urandom;
      1: item.event_time = $urandom_range(0, 15);
      2: item.event_time = 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: item.event_time = $urandom_range(0, 1000);
    endcase
    item.job_number = 16'($urandom_range(0, 16'hFFFF));
    item.event_kind = 3'($urandom_range(0, 7));
    return item;
  endfunction

  task automatic send_req(input req_item_t item);
    while (!calm && $urandom_range(0, 99) < 7) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    sb.note_request(item);
  endtask

  task automatic drain_queue();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);
      rsp_ready <= calm || ($urandom_range(0, 99) >= 7);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    logic [31:0] fill_times [16];
    int insert_pct;
    fill_times = '{32'hFFFF_FFFF, 32'h0, 32'd7, 32'd7, 32'd7, 32'h8000_0000, 32'h0, 32'd3,
                   32'hFFFF_FFFF, 32'd12, 32'd7, 32'd1, 32'd2, 32'd5, 32'd9, 32'd7};
    calm = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_req(make_req(MODE_POP, 32'h0, 16'h0, 3'd0));
    for (int i = 0; i < DEPTH; i++) begin
      send_req(make_req(MODE_INSERT, fill_times[i],
                        (i == 0) ? 16'hFFFF : 16'(i * 16'h1111), 3'(i % 8)));
    end
    send_req(make_req(MODE_INSERT, 32'd4, 16'hABCD, 3'd4));
    repeat (3) send_req(make_req(MODE_POP, 32'hFFFF_FFFF, 16'hFFFF, 3'd7));
    drain_queue();

    insert_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: insert_pct = 25;
          1: insert_pct = 50;
          2: insert_pct = 75;
          default: insert_pct = 90;
        endcase
      end
      calm = (n >= 300 && n < 450);
      if (n == 600) drain_queue();
      send_req(random_req(insert_pct));
    end
    calm = 1'b0;

    drain_queue();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/speq_pkg.sv
rtl/core/speq_cell.sv
rtl/core/sorted_event_priority_queue_top.sv
test/tb_top.sv
